### hw/rtl/pit_pkg.sv
// Shared types, constants and command/status structs for the process id table.
`timescale 1ns / 1ps

package pit_pkg;

    localparam int PID_W     = 15;
    localparam int STAT_W    = 32;
    localparam int SLOTS_DEF = 128;
    localparam int PID_LOW   = 2;
    localparam int PID_HIGH  = 32767;
    localparam int BOOT_ID   = 1;
    localparam int NO_ID     = 0;

    localparam logic [STAT_W-1:0] ST_INIT = 32'h0000_baad;

    typedef enum logic [2:0] {
        MODE_ALLOC   = 3'd0,
        MODE_UNALLOC = 3'd1,
        MODE_DETACH  = 3'd2,
        MODE_EXIT    = 3'd3,
        MODE_JOIN    = 3'd4,
        MODE_ISPAR   = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        OC_OK     = 3'd0,
        OC_FULL   = 3'd1,
        OC_NOSUCH = 3'd2,
        OC_INVAL  = 3'd3,
        OC_DEADLK = 3'd4,
        OC_BLOCK  = 3'd5
    } outcome_t;

    typedef enum logic [1:0] {
        SEL_KEY   = 2'd0,
        SEL_CAND  = 2'd1,
        SEL_SWEEP = 2'd2
    } addr_sel_t;

    typedef enum logic [2:0] {
        WR_INIT   = 3'd0,
        WR_ALLOC  = 3'd1,
        WR_FREE   = 3'd2,
        WR_DETACH = 3'd3,
        WR_EXIT   = 3'd4
    } wr_kind_t;

    typedef enum logic [1:0] {
        RP_NONE   = 2'd0,
        RP_CAND   = 2'd1,
        RP_TARGET = 2'd2
    } res_pid_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_MOD,
        ST_KEY_RD,
        ST_KEY_EVAL,
        ST_SCAN_RD,
        ST_SCAN_EVAL,
        ST_SWEEP_RD,
        ST_SWEEP_EVAL,
        ST_EXIT_RD,
        ST_EXIT_EVAL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              used;
        logic [PID_W-1:0]  id;
        logic [PID_W-1:0]  parent;
        logic              exited;
        logic [STAT_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic      load_in;
        logic      rd_en;
        addr_sel_t rd_sel;
        logic      wr_en;
        addr_sel_t wr_sel;
        wr_kind_t  wr_kind;
        logic      cnt_inc;
        logic      cnt_dec;
        logic      cand_adv;
        logic      scan_clr;
        logic      idx_clr;
        logic      idx_inc;
        logic      res_we;
        outcome_t  res_code;
        res_pid_t  res_pid;
        logic      res_stat;
        logic      res_ans;
        logic      out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  mod_busy;
        logic  known;
        logic  used;
        logic  range_bad;
        logic  exited;
        logic  parent_eq_caller;
        logic  parent_noid;
        logic  parent_eq_other;
        logic  tgt_special;
        logic  caller_eq_target;
        logic  detach_all;
        logic  no_hang;
        logic  child_ok;
        logic  full;
        logic  scan_end;
        logic  idx_last;
        logic  out_free;
    } dp_status_t;

endpackage

### hw/rtl/pit_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pit_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/pit_dp.sv
// Datapath: operand registers, slot remainder unit, candidate, table RAM, result.
`timescale 1ns / 1ps

module pit_dp import pit_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [2:0]        s_mode,
    input  logic [PID_W-1:0]  s_caller_pid,
    input  logic [PID_W-1:0]  s_target_pid,
    input  logic [PID_W-1:0]  s_other_pid,
    input  logic [STAT_W-1:0] s_exit_value,
    input  logic              s_detach_children,
    input  logic              s_no_hang,
    input  ctrl_cmd_t         cmd,
    output dp_status_t        status,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_outcome,
    output logic [PID_W-1:0]  m_result_pid,
    output logic [STAT_W-1:0] m_result_status,
    output logic              m_answer_flag
);

    localparam int SW  = $clog2(SLOTS);
    localparam int CW  = $clog2(SLOTS + 1);
    localparam int RSH = PID_W + SW;
    localparam int MW  = PID_W + 1;
    localparam logic [SW-1:0]    BOOT_SLOT = SW'(BOOT_ID % SLOTS);
    localparam logic [SW-1:0]    LOW_SLOT  = SW'(PID_LOW % SLOTS);
    localparam logic [SW-1:0]    LAST_SLOT = SW'(SLOTS - 1);
    localparam logic [PID_W-1:0] SPAN      = PID_W'(PID_HIGH - PID_LOW + 1);
    localparam logic [CW-1:0]    FULL_CNT  = CW'(SLOTS);
    localparam logic [MW-1:0]    RECIP     = MW'(((1 << RSH) + SLOTS - 1) / SLOTS);
    localparam logic [PID_W-1:0] SLOTS_PID = PID_W'(SLOTS);

    // operand registers
    mode_t             mode_reg;
    logic [PID_W-1:0]  caller_reg, target_reg, other_reg;
    logic [STAT_W-1:0] value_reg;
    logic              detach_reg, nohang_reg;

    // remainder unit
    logic [PID_W-1:0]    key_reg, key_next;
    logic [PID_W-1:0]    quo_reg, quo_next;
    logic [PID_W-1:0]    rem_reg, rem_next;
    logic [1:0]          phase_reg, phase_next;
    logic [PID_W+MW-1:0] prod;

    // allocation and sweep state
    logic [PID_W-1:0] cand_reg, cand_next;
    logic [SW-1:0]    cslot_reg, cslot_next;
    logic [PID_W-1:0] scan_reg, scan_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [SW-1:0]    idx_reg, idx_next;

    // result and output
    outcome_t          res_code_reg;
    logic [PID_W-1:0]  res_pid_reg;
    logic [STAT_W-1:0] res_stat_reg;
    logic              res_ans_reg;
    logic              m_valid_reg, m_valid_next;
    logic [2:0]        m_outcome_reg;
    logic [PID_W-1:0]  m_pid_reg;
    logic [STAT_W-1:0] m_stat_reg;
    logic              m_ans_reg;

    // RAM
    logic [SW-1:0]          key_slot, rd_addr, wr_addr;
    logic [$bits(entry_t)-1:0] rd_data;
    entry_t                 rd_ent, wr_ent;
    logic [PID_W-1:0]       key_pid;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            mode_reg   <= mode_t'(s_mode);
            caller_reg <= s_caller_pid;
            target_reg <= s_target_pid;
            other_reg  <= s_other_pid;
            value_reg  <= s_exit_value;
            detach_reg <= s_detach_children;
            nohang_reg <= s_no_hang;
        end
        if (cmd.res_we) begin
            res_code_reg <= cmd.res_code;
            case (cmd.res_pid)
                RP_CAND:   res_pid_reg <= cand_reg;
                RP_TARGET: res_pid_reg <= target_reg;
                default:   res_pid_reg <= '0;
            endcase
            res_stat_reg <= cmd.res_stat ? rd_ent.value : '0;
            res_ans_reg  <= cmd.res_ans;
        end
        if (cmd.out_load) begin
            m_outcome_reg <= res_code_reg;
            m_pid_reg     <= res_pid_reg;
            m_stat_reg    <= res_stat_reg;
            m_ans_reg     <= res_ans_reg;
        end
        key_reg <= key_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    // reciprocal remainder: quotient by multiply and shift, then subtract
    always_comb begin
        prod       = {{MW{1'b0}}, key_reg} * {{PID_W{1'b0}}, RECIP};
        key_next   = key_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        phase_next = phase_reg;
        if (cmd.load_in) begin
            key_next   = (mode_t'(s_mode) == MODE_EXIT) ? s_caller_pid : s_target_pid;
            phase_next = 2'd2;
        end else if (phase_reg == 2'd2) begin
            quo_next   = PID_W'(prod >> RSH);
            phase_next = 2'd1;
        end else if (phase_reg == 2'd1) begin
            rem_next   = key_reg - PID_W'(quo_reg * SLOTS_PID);
            phase_next = 2'd0;
        end
    end

    always_comb begin
        cand_next  = cand_reg;
        cslot_next = cslot_reg;
        if (cmd.cand_adv) begin
            if (cand_reg == PID_W'(PID_HIGH)) begin
                cand_next  = PID_W'(PID_LOW);
                cslot_next = LOW_SLOT;
            end else begin
                cand_next  = cand_reg + 1'b1;
                cslot_next = (cslot_reg == LAST_SLOT) ? '0 : cslot_reg + 1'b1;
            end
        end
        scan_next = cmd.scan_clr ? '0 : (cmd.cand_adv ? scan_reg + 1'b1 : scan_reg);
        cnt_next  = cnt_reg;
        if (cmd.cnt_inc) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (cmd.cnt_dec) begin
            cnt_next = cnt_reg - 1'b1;
        end
        idx_next = cmd.idx_clr ? '0 : (cmd.idx_inc ? idx_reg + 1'b1 : idx_reg);
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= 2'd0;
            cand_reg    <= PID_W'(PID_LOW);
            cslot_reg   <= LOW_SLOT;
            scan_reg    <= '0;
            cnt_reg     <= CW'(1);
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            cand_reg    <= cand_next;
            cslot_reg   <= cslot_next;
            scan_reg    <= scan_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign key_slot = rem_reg[SW-1:0];
    assign key_pid  = (mode_reg == MODE_EXIT) ? caller_reg : target_reg;
    assign rd_ent   = entry_t'(rd_data);

    always_comb begin
        case (cmd.rd_sel)
            SEL_CAND:  rd_addr = cslot_reg;
            SEL_SWEEP: rd_addr = idx_reg;
            default:   rd_addr = key_slot;
        endcase
        case (cmd.wr_sel)
            SEL_CAND:  wr_addr = cslot_reg;
            SEL_SWEEP: wr_addr = idx_reg;
            default:   wr_addr = key_slot;
        endcase
        wr_ent        = '0;
        wr_ent.parent = PID_W'(NO_ID);
        case (cmd.wr_kind)
            WR_INIT: begin
                if (idx_reg == BOOT_SLOT) begin
                    wr_ent.used  = 1'b1;
                    wr_ent.id    = PID_W'(BOOT_ID);
                    wr_ent.value = ST_INIT;
                end
            end
            WR_ALLOC: begin
                wr_ent.used   = 1'b1;
                wr_ent.id     = cand_reg;
                wr_ent.parent = caller_reg;
                wr_ent.value  = ST_INIT;
            end
            WR_DETACH: begin
                wr_ent        = rd_ent;
                wr_ent.parent = PID_W'(NO_ID);
            end
            WR_EXIT: begin
                wr_ent        = rd_ent;
                wr_ent.exited = 1'b1;
                wr_ent.value  = value_reg;
            end
            default: begin
                wr_ent = wr_ent;
            end
        endcase
    end

    pit_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(SLOTS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_ent),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        status.mode             = mode_reg;
        status.mod_busy         = phase_reg != 2'd0;
        status.known            = rd_ent.used && (rd_ent.id == key_pid);
        status.used             = rd_ent.used;
        status.range_bad        = (target_reg < PID_W'(PID_LOW)) ||
                                  (target_reg > PID_W'(PID_HIGH));
        status.exited           = rd_ent.exited;
        status.parent_eq_caller = rd_ent.parent == caller_reg;
        status.parent_noid      = rd_ent.parent == PID_W'(NO_ID);
        status.parent_eq_other  = rd_ent.parent == other_reg;
        status.tgt_special      = (target_reg == PID_W'(NO_ID)) ||
                                  (target_reg == PID_W'(BOOT_ID));
        status.caller_eq_target = caller_reg == target_reg;
        status.detach_all       = detach_reg;
        status.no_hang          = nohang_reg;
        status.child_ok         = rd_ent.used && (rd_ent.parent == caller_reg) &&
                                  (rd_ent.id != PID_W'(NO_ID)) &&
                                  (rd_ent.id != PID_W'(BOOT_ID));
        status.full             = cnt_reg >= FULL_CNT;
        status.scan_end         = scan_reg == SPAN;
        status.idx_last         = idx_reg == LAST_SLOT;
        status.out_free         = !m_valid_reg || m_ready;
    end

    assign m_valid         = m_valid_reg;
    assign m_outcome       = m_outcome_reg;
    assign m_result_pid    = m_pid_reg;
    assign m_result_status = m_stat_reg;
    assign m_answer_flag   = m_ans_reg;

endmodule

### hw/rtl/pit_ctrl.sv
// Controller state machine sequencing table reads, writes and the result.
`timescale 1ns / 1ps

module pit_ctrl import pit_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = SEL_SWEEP;
                cmd.wr_kind = WR_INIT;
                if (status.idx_last) begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_IDLE;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (status.mode)
                    MODE_ALLOC: begin
                        if (status.full) begin
                            cmd.res_we   = 1'b1;
                            cmd.res_code = OC_FULL;
                            state_next   = ST_DONE;
                        end else begin
                            cmd.scan_clr = 1'b1;
                            state_next   = ST_SCAN_RD;
                        end
                    end
                    MODE_UNALLOC, MODE_DETACH, MODE_EXIT, MODE_JOIN, MODE_ISPAR: begin
                        state_next = ST_MOD;
                    end
                    default: begin
                        cmd.res_we   = 1'b1;
                        cmd.res_code = OC_INVAL;
                        state_next   = ST_DONE;
                    end
                endcase
            end
            ST_MOD: begin
                if (!status.mod_busy) begin
                    state_next = ST_KEY_RD;
                end
            end
            ST_KEY_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = SEL_KEY;
                state_next = ST_KEY_EVAL;
            end
            ST_KEY_EVAL: begin
                cmd.res_we   = 1'b1;
                cmd.res_code = OC_OK;
                state_next   = ST_DONE;
                if (!status.known) begin
                    cmd.res_code = OC_NOSUCH;
                end else begin
                    case (status.mode)
                        MODE_UNALLOC: begin
                            if (status.range_bad || status.exited ||
                                    !status.parent_eq_caller) begin
                                cmd.res_code = OC_INVAL;
                            end else begin
                                cmd.wr_en   = 1'b1;
                                cmd.wr_sel  = SEL_KEY;
                                cmd.wr_kind = WR_FREE;
                                cmd.cnt_dec = 1'b1;
                            end
                        end
                        MODE_DETACH: begin
                            if (status.tgt_special) begin
                                cmd.res_code = OC_INVAL;
                            end else begin
                                cmd.wr_en   = 1'b1;
                                cmd.wr_sel  = SEL_KEY;
                                cmd.wr_kind = WR_DETACH;
                            end
                        end
                        MODE_EXIT: begin
                            cmd.res_we = 1'b0;
                            if (status.detach_all) begin
                                cmd.idx_clr = 1'b1;
                                state_next  = ST_SWEEP_RD;
                            end else begin
                                state_next = ST_EXIT_RD;
                            end
                        end
                        MODE_JOIN: begin
                            if (status.tgt_special) begin
                                cmd.res_code = OC_INVAL;
                            end else if (status.caller_eq_target) begin
                                cmd.res_code = OC_DEADLK;
                            end else if (status.parent_noid) begin
                                cmd.res_code = OC_INVAL;
                            end else if (!status.exited && !status.no_hang) begin
                                cmd.res_code = OC_BLOCK;
                            end else begin
                                cmd.res_pid  = RP_TARGET;
                                cmd.res_stat = 1'b1;
                            end
                        end
                        default: begin
                            cmd.res_ans = status.parent_eq_other;
                        end
                    endcase
                end
            end
            ST_SWEEP_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = SEL_SWEEP;
                state_next = ST_SWEEP_EVAL;
            end
            ST_SWEEP_EVAL: begin
                if (status.child_ok) begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = SEL_SWEEP;
                    cmd.wr_kind = WR_DETACH;
                end
                if (status.idx_last) begin
                    state_next = ST_EXIT_RD;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_SWEEP_RD;
                end
            end
            ST_EXIT_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = SEL_KEY;
                state_next = ST_EXIT_EVAL;
            end
            ST_EXIT_EVAL: begin
                cmd.wr_en    = 1'b1;
                cmd.wr_sel   = SEL_KEY;
                cmd.res_we   = 1'b1;
                cmd.res_code = OC_OK;
                if (status.parent_noid) begin
                    cmd.wr_kind = WR_FREE;
                    cmd.cnt_dec = 1'b1;
                end else begin
                    cmd.wr_kind = WR_EXIT;
                end
                state_next = ST_DONE;
            end
            ST_SCAN_RD: begin
                if (status.scan_end) begin
                    cmd.res_we   = 1'b1;
                    cmd.res_code = OC_FULL;
                    state_next   = ST_DONE;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = SEL_CAND;
                    state_next = ST_SCAN_EVAL;
                end
            end
            ST_SCAN_EVAL: begin
                cmd.cand_adv = 1'b1;
                if (status.used) begin
                    state_next = ST_SCAN_RD;
                end else begin
                    cmd.wr_en    = 1'b1;
                    cmd.wr_sel   = SEL_CAND;
                    cmd.wr_kind  = WR_ALLOC;
                    cmd.cnt_inc  = 1'b1;
                    cmd.res_we   = 1'b1;
                    cmd.res_code = OC_OK;
                    cmd.res_pid  = RP_CAND;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/process_id_table_top.sv
// Top level of the process id table: controller, datapath and result channel.
// Sequence: allocate scans candidate slots, reading and checking each, until a free one is found;
//   unallocate, detach, join and is-parent wait for the reciprocal slot remainder, then read and
//   check the keyed entry; exit does the same, plus a sweep of all SLOTS when children are detached.
// Throughput: one beat at a time; the next beat is taken the cycle after the result loads.
// Reset: a clearing pass writes every table entry; s_ready stays low meanwhile.
`timescale 1ns / 1ps

module process_id_table_top import pit_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_mode,
    input  logic [PID_W-1:0]  s_caller_pid,
    input  logic [PID_W-1:0]  s_target_pid,
    input  logic [PID_W-1:0]  s_other_pid,
    input  logic [STAT_W-1:0] s_exit_value,
    input  logic              s_detach_children,
    input  logic              s_no_hang,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_outcome,
    output logic [PID_W-1:0]  m_result_pid,
    output logic [STAT_W-1:0] m_result_status,
    output logic              m_answer_flag
);

    // Command and status between the sequencer and the table datapath.
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequence each beat: dispatch on mode, scan for a free slot on allocate or wait
    // for the slot remainder, read and check the entry, sweep for children on exit
    // when asked, then hold the result until the output register is free.
    pit_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Hold the operands, the table RAM, the allocation candidate, the used
    // count and the output register that parts the result side from the input.
    pit_dp #(
        .SLOTS(SLOTS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_mode            (s_mode),
        .s_caller_pid      (s_caller_pid),
        .s_target_pid      (s_target_pid),
        .s_other_pid       (s_other_pid),
        .s_exit_value      (s_exit_value),
        .s_detach_children (s_detach_children),
        .s_no_hang         (s_no_hang),
        .cmd               (cmd),
        .status            (status),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_outcome         (m_outcome),
        .m_result_pid      (m_result_pid),
        .m_result_status   (m_result_status),
        .m_answer_flag     (m_answer_flag)
    );

endmodule

### sim/process_id_table_top_tb.sv
// Self-checking testbench for the process id table top level.
`timescale 1ns / 1ps

module process_id_table_top_tb;
    import pit_pkg::*;

    localparam int SLOTS = SLOTS_DEF;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam logic [STAT_W-1:0] ST_DEAD = 32'h0000_dead;
    localparam logic [PID_W-1:0] BOOT_PID = PID_W'(BOOT_ID);
    localparam logic [PID_W-1:0] NO_PID   = PID_W'(NO_ID);

    // One result beat as the block should present it.
    typedef struct packed {
        logic [2:0]        outcome;
        logic [PID_W-1:0]  pid;
        logic [STAT_W-1:0] status;
        logic              answer;
    } reply_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [2:0]        s_mode = '0;
    logic [PID_W-1:0]  s_caller_pid = '0;
    logic [PID_W-1:0]  s_target_pid = '0;
    logic [PID_W-1:0]  s_other_pid = '0;
    logic [STAT_W-1:0] s_exit_value = '0;
    logic              s_detach_children = 1'b0;
    logic              s_no_hang = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [2:0]        m_outcome;
    logic [PID_W-1:0]  m_result_pid;
    logic [STAT_W-1:0] m_result_status;
    logic              m_answer_flag;

    // Shadow of the process table.
    logic              tbl_used   [SLOTS];
    logic [PID_W-1:0]  tbl_id     [SLOTS];
    logic [PID_W-1:0]  tbl_parent [SLOTS];
    logic              tbl_exited [SLOTS];
    logic [STAT_W-1:0] tbl_value  [SLOTS];
    logic [PID_W-1:0]  next_pid;
    int                live_count;
    bit                pid_wrapped;

    reply_t awaited_replies[$];
    int     mismatches = 0;
    int     idle_cycles = 0;
    bit     idling_on = 1'b1;
    int     stall_left = 0;

    process_id_table_top #(.SLOTS(SLOTS)) DUT (.*);

    always #2 aclk = ~aclk;

    // ---------------------------------------------------------------
    // Shadow model
    // ---------------------------------------------------------------
    function automatic int slot_of(logic [PID_W-1:0] pid);
        return pid % SLOTS;
    endfunction

    function automatic bit is_known(logic [PID_W-1:0] pid);
        return tbl_used[slot_of(pid)] && tbl_id[slot_of(pid)] == pid;
    endfunction

    function automatic logic [PID_W-1:0] step_pid(logic [PID_W-1:0] pid);
        return (pid == PID_HIGH[PID_W-1:0]) ? PID_LOW[PID_W-1:0] : pid + 1'b1;
    endfunction

    function automatic void free_entry(int s);
        tbl_used[s]   = 1'b0;
        tbl_id[s]     = '0;
        tbl_parent[s] = NO_ID[PID_W-1:0];
        tbl_exited[s] = 1'b0;
        tbl_value[s]  = '0;
        if (live_count > 0) live_count--;
    endfunction

    function automatic void clear_table();
        int b;
        b = slot_of(BOOT_ID[PID_W-1:0]);
        for (int i = 0; i < SLOTS; i++) begin
            tbl_used[i] = 1'b0; tbl_id[i] = '0; tbl_parent[i] = NO_ID[PID_W-1:0];
            tbl_exited[i] = 1'b0; tbl_value[i] = '0;
        end
        tbl_used[b]  = 1'b1;
        tbl_id[b]    = BOOT_ID[PID_W-1:0];
        tbl_value[b] = ST_INIT;
        next_pid     = PID_LOW[PID_W-1:0];
        live_count   = 1;
    endfunction

    // Apply one request to the shadow table and return the reply it earns.
    function automatic reply_t apply_request(logic [2:0] mode, logic [PID_W-1:0] caller,
            logic [PID_W-1:0] target, logic [PID_W-1:0] other, logic [STAT_W-1:0] value,
            logic detach_all, logic no_hang);
        reply_t r;
        int s, m, n, t;
        r = '0;
        r.outcome = OC_INVAL;
        s = slot_of(target);
        case (mode)
            MODE_ALLOC: begin
                if (live_count >= SLOTS) begin
                    r.outcome = OC_FULL;
                end else begin
                    n = 0;
                    while (n < PID_HIGH - PID_LOW + 1 && tbl_used[slot_of(next_pid)]) begin
                        if (next_pid == PID_HIGH[PID_W-1:0]) pid_wrapped = 1'b1;
                        next_pid = step_pid(next_pid);
                        n++;
                    end
                    if (n >= PID_HIGH - PID_LOW + 1) begin
                        r.outcome = OC_FULL;
                    end else begin
                        t = slot_of(next_pid);
                        tbl_used[t] = 1'b1; tbl_id[t] = next_pid; tbl_parent[t] = caller;
                        tbl_exited[t] = 1'b0; tbl_value[t] = ST_INIT;
                        live_count++;
                        r.outcome = OC_OK;
                        r.pid = next_pid;
                        if (next_pid == PID_HIGH[PID_W-1:0]) pid_wrapped = 1'b1;
                        next_pid = step_pid(next_pid);
                    end
                end
            end
            MODE_UNALLOC: begin
                if (!is_known(target)) r.outcome = OC_NOSUCH;
                else if (target < PID_LOW || target > PID_HIGH || tbl_exited[s]
                         || tbl_parent[s] != caller) r.outcome = OC_INVAL;
                else begin
                    free_entry(s);
                    r.outcome = OC_OK;
                end
            end
            MODE_DETACH: begin
                if (!is_known(target)) r.outcome = OC_NOSUCH;
                else if (target == NO_ID || target == BOOT_ID) r.outcome = OC_INVAL;
                else begin
                    tbl_parent[s] = NO_ID[PID_W-1:0];
                    r.outcome = OC_OK;
                end
            end
            MODE_EXIT: begin
                if (!is_known(caller)) begin
                    r.outcome = OC_NOSUCH;
                end else begin
                    m = slot_of(caller);
                    // Children lose their parent, but only ordinary ids can be detached.
                    if (detach_all)
                        for (int i = 0; i < SLOTS; i++)
                            if (tbl_used[i] && tbl_parent[i] == caller
                                && tbl_id[i] != NO_ID && tbl_id[i] != BOOT_ID)
                                tbl_parent[i] = NO_ID[PID_W-1:0];
                    tbl_value[m]  = value;
                    tbl_exited[m] = 1'b1;
                    if (tbl_parent[m] == NO_ID) free_entry(m);
                    r.outcome = OC_OK;
                end
            end
            MODE_JOIN: begin
                if (!is_known(target)) r.outcome = OC_NOSUCH;
                else if (target == NO_ID || target == BOOT_ID) r.outcome = OC_INVAL;
                else if (caller == target) r.outcome = OC_DEADLK;
                else if (tbl_parent[s] == NO_ID) r.outcome = OC_INVAL;
                else if (!tbl_exited[s] && !no_hang) r.outcome = OC_BLOCK;
                else begin
                    r.outcome = OC_OK;
                    r.pid = target;
                    r.status = tbl_value[s];
                end
            end
            MODE_ISPAR: begin
                if (!is_known(target)) r.outcome = OC_NOSUCH;
                else begin
                    r.outcome = OC_OK;
                    r.answer = (tbl_parent[s] == other);
                end
            end
            default: r.outcome = OC_INVAL;
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------
    // Send one request beat, optionally after an idle burst, and log its reply.
    task automatic issue_request(input logic [2:0] mode, input logic [PID_W-1:0] caller,
            input logic [PID_W-1:0] target, input logic [PID_W-1:0] other,
            input logic [STAT_W-1:0] value, input logic detach_all, input logic no_hang,
            output reply_t r);
        int gap;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_mode <= mode;
        s_caller_pid <= caller;
        s_target_pid <= target;
        s_other_pid <= other;
        s_exit_value <= value;
        s_detach_children <= detach_all;
        s_no_hang <= no_hang;
        s_valid <= 1'b1;
        // Hold the beat until the block takes it.
        do @(posedge aclk); while (!s_ready);
        r = apply_request(mode, caller, target, other, value, detach_all, no_hang);
        awaited_replies.push_back(r);
    endtask

    task automatic quick(input logic [2:0] mode, input logic [PID_W-1:0] caller,
            input logic [PID_W-1:0] target, input logic [PID_W-1:0] other = '0,
            input logic [STAT_W-1:0] value = '0, input logic detach_all = 1'b0,
            input logic no_hang = 1'b0);
        reply_t r;
        issue_request(mode, caller, target, other, value, detach_all, no_hang, r);
    endtask

    // Drop valid and wait for every outstanding reply.
    task automatic drain_replies();
        s_valid <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge aclk);
    endtask

    // Pick an id: mostly live ones, sometimes special, aliased or fully random.
    function automatic logic [PID_W-1:0] pick_pid();
        int k, s;
        k = $urandom_range(0, 9);
        if (k <= 5) begin
            for (int tries = 0; tries < 8; tries++) begin
                s = $urandom_range(0, SLOTS - 1);
                if (tbl_used[s]) return tbl_id[s];
            end
            return BOOT_ID[PID_W-1:0];
        end
        if (k == 6) return BOOT_ID[PID_W-1:0];
        if (k == 7) return NO_ID[PID_W-1:0];
        if (k == 8) return PID_W'(next_pid + SLOTS * $urandom_range(0, 255));
        return PID_W'($urandom);
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_basic_ops();
        quick(MODE_ALLOC, BOOT_PID, '0);                      // gets 2
        quick(MODE_ALLOC, 15'd2, 15'h7fff);                   // gets 3, parent 2
        quick(MODE_ISPAR, '0, 15'd3, 15'd2);
        quick(MODE_ISPAR, '0, 15'd3, 15'h7fff);
        quick(MODE_ISPAR, '0, 15'h7fff, 15'd2);               // unknown target
        quick(MODE_JOIN, 15'd2, 15'd3, '0, '0, 1'b0, 1'b0);   // would block
        quick(MODE_JOIN, 15'd2, 15'd3, '0, '0, 1'b0, 1'b1);   // no wait, initial status
        quick(MODE_JOIN, 15'd2, BOOT_PID);
        quick(MODE_JOIN, 15'd3, 15'd3);                       // self join
        quick(MODE_JOIN, 15'd2, 15'h7fff);
        quick(MODE_DETACH, 15'd2, BOOT_PID);
        quick(MODE_DETACH, 15'd2, NO_PID);
        quick(MODE_EXIT, 15'd3, '0, '0, 32'h8000_0000);
        quick(MODE_JOIN, 15'd2, 15'd3);                       // exited: ok with status
        quick(MODE_EXIT, 15'd3, '0, '0, 32'h7fff_ffff);       // second exit overwrites
        quick(MODE_UNALLOC, 15'd2, 15'd3);                    // exited target
        quick(MODE_EXIT, 15'd2, '0, '0, 32'hffff_ffff, 1'b1); // detach all children
        quick(MODE_JOIN, 15'd2, 15'd3);                       // detached target
        quick(MODE_UNALLOC, 15'h7fff, BOOT_PID);              // boot out of range
        quick(MODE_UNALLOC, BOOT_PID, 15'd130);               // alias of slot 2
        quick(MODE_EXIT, 15'h7fff, '0, '0, ST_DEAD);          // unknown caller
        quick(MODE_DETACH, BOOT_PID, 15'd2);
        quick(MODE_EXIT, 15'd2, '0, '0, '0);                  // detached caller leaves
        quick(MODE_SPARE_LO, 15'h7fff, 15'h7fff, 15'h7fff, '1, 1'b1, 1'b1);
        quick(MODE_SPARE_HI, '0, '0);
        drain_replies();
    endtask

    // Fill the table, hit the full refusal, then cycle the free slot until
    // the id counter wraps past the top of its range.
    task automatic test_full_and_wrap();
        reply_t r;
        logic [PID_W-1:0] last;
        last = '0;
        while (live_count < SLOTS) begin
            issue_request(MODE_ALLOC, BOOT_PID, '0, '0, '0, 1'b0, 1'b0, r);
            if (r.outcome == OC_OK) last = r.pid;
        end
        quick(MODE_ALLOC, BOOT_PID, '0);
        pid_wrapped = 1'b0;
        for (int i = 0; i < 300 && !(pid_wrapped && i > 4); i++) begin
            quick(MODE_UNALLOC, BOOT_PID, last);
            issue_request(MODE_ALLOC, BOOT_PID, '0, '0, '0, 1'b0, 1'b0, r);
            last = r.pid;
        end
        for (int s = 0; s < SLOTS; s++)
            if (tbl_used[s] && tbl_parent[s] == BOOT_ID && !tbl_exited[s])
                quick(MODE_UNALLOC, BOOT_PID, tbl_id[s]);
        // Hold off new requests until the table has settled.
        drain_replies();
    endtask

    task automatic test_random_traffic(input int count);
        logic [2:0] mode;
        logic [PID_W-1:0] caller, target, other;
        int k;
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(0, 99);
            if (k < 25)      mode = MODE_ALLOC;
            else if (k < 40) mode = MODE_UNALLOC;
            else if (k < 50) mode = MODE_DETACH;
            else if (k < 68) mode = MODE_EXIT;
            else if (k < 85) mode = MODE_JOIN;
            else if (k < 96) mode = MODE_ISPAR;
            else             mode = $urandom_range(0, 1) ? MODE_SPARE_LO : MODE_SPARE_HI;
            caller = pick_pid();
            target = pick_pid();
            other  = pick_pid();
            // Steer toward legal parent/child pairs so deep paths get hit.
            if (is_known(target) && $urandom_range(0, 9) < 7) begin
                if (mode == MODE_UNALLOC || mode == MODE_JOIN) caller = tbl_parent[slot_of(target)];
                if (mode == MODE_ISPAR) other = tbl_parent[slot_of(target)];
            end
            if (live_count > SLOTS - 8 && $urandom_range(0, 1) && mode == MODE_ALLOC)
                mode = MODE_EXIT;
            quick(mode, caller, target, other, $urandom, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
        end
    endtask

    // ---------------------------------------------------------------
    // Reply side: random stall bursts on m_ready, then check each beat.
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        logic nxt;
        nxt = 1'b1;
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            nxt = 1'b0;
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 14);
            nxt = 1'b0;
        end
        m_ready <= nxt;
    end

    always @(posedge aclk) begin
        reply_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reply beat: outcome %0d pid %0d", m_outcome, m_result_pid);
            end else begin
                exp_r = awaited_replies.pop_front();
                if (m_outcome !== exp_r.outcome || m_result_pid !== exp_r.pid
                    || m_result_status !== exp_r.status || m_answer_flag !== exp_r.answer) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reply mismatch: exp oc %0d pid %0d st %h ans %0b, got oc %0d pid %0d st %h ans %0b",
                                 exp_r.outcome, exp_r.pid, exp_r.status, exp_r.answer,
                                 m_outcome, m_result_pid, m_result_status, m_answer_flag);
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves on either channel for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (aresetn) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        clear_table();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        // The first beat waits for s_ready, which stays low through the clearing pass.
        @(posedge aclk);
        test_basic_ops();
        test_full_and_wrap();
        test_random_traffic(260);
        drain_replies();
        idling_on = 1'b0;
        test_random_traffic(100);
        drain_replies();
        repeat (300) @(posedge aclk);
        if (mismatches == 0 && awaited_replies.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
